// ----- hdl/sleu_pkg.sv -----
package sleu_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QAW       = $clog2(QDEPTH);

    localparam logic [CP_W-1:0] CP_NUL    = 21'h00;
    localparam logic [CP_W-1:0] CP_LF     = 21'h0A;
    localparam logic [CP_W-1:0] CP_DQUOTE = 21'h22;
    localparam logic [CP_W-1:0] CP_SQUOTE = 21'h27;
    localparam logic [CP_W-1:0] CP_BSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CP_LC_B   = 21'h62;
    localparam logic [CP_W-1:0] CP_LC_N   = 21'h6E;
    localparam logic [CP_W-1:0] CP_LC_T   = 21'h74;
    localparam logic [CP_W-1:0] CP_LC_R   = 21'h72;
    localparam logic [CP_W-1:0] CP_LC_E   = 21'h65;
    localparam logic [CP_W-1:0] CP_LC_X   = 21'h78;
    localparam logic [CP_W-1:0] CP_LC_U   = 21'h75;
    localparam logic [CP_W-1:0] CP_UC_U   = 21'h55;
    localparam logic [CP_W-1:0] CP_BS     = 21'h08;
    localparam logic [CP_W-1:0] CP_TAB    = 21'h09;
    localparam logic [CP_W-1:0] CP_CR     = 21'h0D;
    localparam logic [CP_W-1:0] CP_ESC    = 21'h1B;
    localparam logic [31:0]     MAX_CP    = 32'h0010_FFFF;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_OK        = 2'd1,
        KIND_UNCLOSED  = 2'd2,
        KIND_INVALID   = 2'd3
    } t_kind;

    // Work for one accepted item: up to two code points to encode, then an
    // optional ending result. b_en is only set together with a_en.
    typedef struct packed {
        logic            a_en;
        logic [CP_W-1:0] a_cp;
        logic            b_en;
        logic [CP_W-1:0] b_cp;
        logic            end_en;
        t_kind           end_kind;
        logic            end_taken;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // Number of UTF-8 bytes minus one.
    function automatic logic [1:0] f_utf8_last(input logic [CP_W-1:0] cp);
        logic [1:0] n;
        if (cp < 21'h80)         n = 2'd0;
        else if (cp < 21'h800)   n = 2'd1;
        else if (cp < 21'h10000) n = 2'd2;
        else                     n = 2'd3;
        return n;
    endfunction

    function automatic logic [7:0] f_utf8_byte(input logic [CP_W-1:0] cp,
                                               input logic [1:0]      idx);
        logic [1:0] last;
        logic [7:0] b;
        last = f_utf8_last(cp);
        b    = 8'h00;
        case (last)
            2'd0: b = {1'b0, cp[6:0]};
            2'd1: b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
            2'd2: begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ----- hdl/sleu_front.sv -----
module sleu_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [sleu_pkg::CP_W-1:0]   i_cp,
    input  logic                        i_begin,
    input  sleu_pkg::t_qstat            i_qstat,
    output logic                        o_ready,
    output logic                        o_push,
    output sleu_pkg::t_cmd              o_cmd
);
    import sleu_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_TEXT = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } t_mode;

    t_mode       r_mode, n_mode;
    logic        r_sq, n_sq;
    logic [31:0] r_hex_value, n_hex_value;
    logic [3:0]  r_hex_left, n_hex_left;

    logic            accept;
    logic            has_res;
    logic            is_quote;
    logic            is_term;
    logic            cp_bad;
    logic            dig_ok;
    logic [3:0]      dig;
    logic [31:0]     hex_next;
    logic [3:0]      left_next;
    logic [CP_W-1:0] esc_val;
    t_cmd            cmd;

    assign o_ready  = !i_qstat.full;
    assign accept   = i_valid && o_ready;
    assign is_quote = (i_cp == (r_sq ? CP_SQUOTE : CP_DQUOTE));
    assign is_term  = (i_cp == CP_LF) || (i_cp == CP_NUL);
    assign cp_bad   = ({11'd0, i_cp} > MAX_CP);

    always_comb begin
        dig_ok = 1'b1;
        dig    = 4'd0;
        if (i_cp >= 21'h30 && i_cp <= 21'h39)      dig = 4'(i_cp - 21'h30);
        else if (i_cp >= 21'h61 && i_cp <= 21'h66) dig = 4'(i_cp - 21'h57);
        else if (i_cp >= 21'h41 && i_cp <= 21'h46) dig = 4'(i_cp - 21'h37);
        else                                       dig_ok = 1'b0;
    end

    assign hex_next  = {r_hex_value[27:0], dig};
    assign left_next = r_hex_left - 4'd1;

    always_comb begin
        unique case (i_cp)
            CP_LC_B: esc_val = CP_BS;
            CP_LC_N: esc_val = CP_LF;
            CP_LC_T: esc_val = CP_TAB;
            CP_LC_R: esc_val = CP_CR;
            CP_LC_E: esc_val = CP_ESC;
            default: esc_val = i_cp;
        endcase
    end

    always_comb begin
        n_mode      = r_mode;
        n_sq        = r_sq;
        n_hex_value = r_hex_value;
        n_hex_left  = r_hex_left;
        cmd         = '0;
        cmd.a_cp    = i_cp;
        cmd.b_cp    = i_cp;
        cmd.end_kind = KIND_DATA;
        if (i_begin) begin
            n_sq        = (i_cp == CP_SQUOTE);
            n_mode      = MODE_TEXT;
            n_hex_value = '0;
            n_hex_left  = '0;
        end else begin
            unique case (r_mode)
                MODE_TEXT: begin
                    if (is_quote) begin
                        cmd.end_en = 1'b1; cmd.end_kind = KIND_OK; cmd.end_taken = 1'b1;
                    end else if (is_term) begin
                        cmd.end_en = 1'b1; cmd.end_kind = KIND_UNCLOSED;
                    end else if (i_cp == CP_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else if (cp_bad) begin
                        cmd.end_en = 1'b1; cmd.end_kind = KIND_INVALID;
                    end else begin
                        cmd.a_en = 1'b1;
                    end
                end
                MODE_ESC: begin
                    if (i_cp == CP_NUL) begin
                        cmd.end_en = 1'b1; cmd.end_kind = KIND_UNCLOSED;
                    end else if (i_cp == CP_LC_X || i_cp == CP_LC_U || i_cp == CP_UC_U) begin
                        n_mode      = MODE_HEX;
                        n_hex_value = '0;
                        n_hex_left  = (i_cp == CP_LC_X) ? 4'd2 :
                                      (i_cp == CP_LC_U) ? 4'd4 : 4'd8;
                    end else if (cp_bad) begin
                        cmd.end_en = 1'b1; cmd.end_kind = KIND_INVALID;
                    end else begin
                        cmd.a_en = 1'b1;
                        cmd.a_cp = esc_val;
                        n_mode   = MODE_TEXT;
                    end
                end
                MODE_HEX: begin
                    if (dig_ok && r_hex_left != 4'd0) begin
                        n_hex_value = hex_next;
                        n_hex_left  = left_next;
                        if (left_next == 4'd0) begin
                            if (hex_next > MAX_CP) begin
                                cmd.end_en = 1'b1; cmd.end_kind = KIND_INVALID;
                                cmd.end_taken = 1'b1;
                            end else begin
                                cmd.a_en = 1'b1;
                                cmd.a_cp = hex_next[CP_W-1:0];
                                n_mode   = MODE_TEXT;
                            end
                        end
                    end else if (r_hex_value > MAX_CP) begin
                        cmd.end_en = 1'b1; cmd.end_kind = KIND_INVALID;
                    end else begin
                        // flush the digits so far, then treat the char as text
                        cmd.a_en    = 1'b1;
                        cmd.a_cp    = r_hex_value[CP_W-1:0];
                        n_mode      = MODE_TEXT;
                        n_hex_value = '0;
                        n_hex_left  = '0;
                        if (is_quote) begin
                            cmd.end_en = 1'b1; cmd.end_kind = KIND_OK; cmd.end_taken = 1'b1;
                        end else if (is_term) begin
                            cmd.end_en = 1'b1; cmd.end_kind = KIND_UNCLOSED;
                        end else if (i_cp == CP_BSLASH) begin
                            n_mode = MODE_ESC;
                        end else if (cp_bad) begin
                            cmd.end_en = 1'b1; cmd.end_kind = KIND_INVALID;
                        end else begin
                            cmd.b_en = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (cmd.end_en) begin
                n_mode      = MODE_IDLE;
                n_hex_value = '0;
                n_hex_left  = '0;
            end
        end
    end

    assign has_res = cmd.a_en || cmd.end_en;
    assign o_push  = accept && has_res;
    assign o_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_sq        <= 1'b0;
            r_hex_value <= '0;
            r_hex_left  <= '0;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_sq        <= n_sq;
            r_hex_value <= n_hex_value;
            r_hex_left  <= n_hex_left;
        end
    end

    a_b_needs_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.b_en |-> o_cmd.a_en)
        else $error("second code point queued without a first");

    a_hex_left_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_HEX |-> r_hex_left != 4'd0)
        else $error("hex escape active with no digits left");

    a_ready_follows_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_qstat.full)
        else $error("push into a full queue");

endmodule

// ----- hdl/sleu_fifo.sv -----
module sleu_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sleu_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output sleu_pkg::t_cmd   o_cmd,
    output sleu_pkg::t_qstat o_qstat
);
    import sleu_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;

    assign o_cmd         = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + QAW'(1);
            if (i_pop)  r_rptr <= r_rptr + QAW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QAW+1)'(1);
                2'b01:   r_count <= r_count - (QAW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qstat.full && !i_pop |-> !i_push)
        else $error("write to a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("read from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

// ----- hdl/sleu_back.sv -----
module sleu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sleu_pkg::t_cmd   i_cmd,
    input  sleu_pkg::t_qstat i_qstat,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [7:0]       o_byte,
    output sleu_pkg::t_kind  o_kind,
    output logic             o_taken,
    output logic             o_last
);
    import sleu_pkg::*;

    typedef enum logic [2:0] {
        PART_A   = 3'b001,
        PART_B   = 3'b010,
        PART_END = 3'b100
    } t_part;

    t_part      r_part;
    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    t_kind      r_kind;
    logic       r_taken;
    logic       r_last;

    t_part           part;
    logic [CP_W-1:0] cp;
    logic            seg_last;
    logic            done;
    logic            load;
    logic            step;

    always_comb begin
        part = r_part;
        if (r_part == PART_A && !i_cmd.a_en) part = PART_END;
    end

    assign cp       = (part == PART_B) ? i_cmd.b_cp : i_cmd.a_cp;
    assign seg_last = (r_idx == f_utf8_last(cp));

    always_comb begin
        unique case (part)
            PART_A:   done = seg_last && !i_cmd.b_en && !i_cmd.end_en;
            PART_B:   done = seg_last && !i_cmd.end_en;
            PART_END: done = 1'b1;
            default:  done = 1'b1;
        endcase
    end

    assign load  = !r_valid || i_ready;
    assign step  = load && !i_qstat.empty;
    assign o_pop = step && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part  <= PART_A;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) r_valid <= !i_qstat.empty;
            if (step) begin
                if (done) begin
                    r_part <= PART_A;
                    r_idx  <= '0;
                end else if (seg_last) begin
                    // advance to the next segment of this item
                    r_part <= (part == PART_A && i_cmd.b_en) ? PART_B : PART_END;
                    r_idx  <= '0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_last <= done;
            if (part == PART_END) begin
                r_byte  <= 8'h00;
                r_kind  <= i_cmd.end_kind;
                r_taken <= i_cmd.end_taken;
            end else begin
                r_byte  <= f_utf8_byte(cp, r_idx);
                r_kind  <= KIND_DATA;
                r_taken <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_kind  = r_kind;
    assign o_taken = r_taken;
    assign o_last  = r_last;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind != KIND_DATA |-> r_last)
        else $error("ending result not marked last");

    a_data_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_kind == KIND_DATA |-> !r_taken)
        else $error("data byte marked taken");

    a_mid_item_no_idle_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_part != PART_A |-> !i_qstat.empty)
        else $error("segment position kept with no item queued");

endmodule

// ----- hdl/string_literal_unescaper_top.sv -----
// Channel   Dir  Payload                                       Handshake
// s_axis    in   tdata[20:0] code_point, tuser begin_req        tvalid/tready
// m_axis    out  tdata[7:0] byte_res, tuser {taken,kind}, tlast tvalid/tready
//
// Input takes one code point per cycle while the 4-entry command queue has room.
// Output gives one result per cycle while the receiver is ready and the queue is
// not empty: 1 to 4 bytes per encoded code point, up to 8 results per item, so
// multi-byte text holds the input back through the queue.
// Reset is synchronous, active low; it idles the decoder and empties the queue.
// Either side may stall at any time; the output register holds its result.
module string_literal_unescaper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        i_s_axis_tuser,   // [0] begin_req
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] byte_res
    output logic [2:0]  o_m_axis_tuser,   // [1:0] kind, [2] taken
    output logic        o_m_axis_tlast
);
    import sleu_pkg::*;

    t_cmd   push_cmd;
    t_cmd   head_cmd;
    t_qstat qstat;
    logic   push;
    logic   pop;
    t_kind  kind;
    logic   taken;

    sleu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_cp    (i_s_axis_tdata[CP_W-1:0]),
        .i_begin (i_s_axis_tuser),
        .i_qstat (qstat),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    sleu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    sleu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_byte  (o_m_axis_tdata),
        .o_kind  (kind),
        .o_taken (taken),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = {taken, kind};

endmodule
